// ===== rtl/pcr_pkg.sv =====
`timescale 1ns / 1ps
package pcr_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int W = COMPONENT_WIDTH;
  localparam int VW = 3 * W;
  localparam int MW = 16;
  localparam int SW = MW + 1;
  localparam int KW = 10;
  localparam int REST_ONE = 256;
  localparam int REST_SHIFT = 8;
  localparam int GUARD_DROP = 4;
  localparam int DSH = REST_SHIFT + GUARD_DROP;
  localparam int SSH = W - 2;
  localparam int VSH = SSH - GUARD_DROP;
  localparam int QMAG = 2 * W + 10;
  localparam int DIV_LAT = QMAG + 2;
  localparam int DW = 2 * W + 1;

  typedef logic [VW-1:0] vec_t;

  typedef struct packed {
    logic                 has;
    logic                 pneg;
    logic                 qneg;
    logic [2:0]           tneg;
    logic signed [DW-1:0] dscen;
    vec_t                 sscen;
    vec_t                 n;
    vec_t                 v1;
    vec_t                 v2;
  } side_t;

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  // round half away from zero on a sign-magnitude value
  function automatic logic signed [63:0] rnd_sm(input logic neg, input logic [63:0] mag,
                                                 input int unsigned s);
    logic [63:0] m;
    m = (mag + (64'd1 << (s - 1))) >> s;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [W-1:0] sat_comp(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (W - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (W - 1));
    if (x > hi) return W'(hi);
    if (x < lo) return W'(lo);
    return W'(x);
  endfunction

endpackage

// ===== rtl/pcr_if.sv =====
`timescale 1ns / 1ps
interface pcr_in_if;
  logic                                valid;
  logic                                ready;
  logic [pcr_pkg::VW-1:0]              normal;
  logic [pcr_pkg::VW-1:0]              velocity_one;
  logic [pcr_pkg::VW-1:0]              velocity_two;
  logic [15:0]                         mass_one;
  logic [15:0]                         mass_two;
  logic                                has_second;
  logic [8:0]                          restitution;
  logic signed [15:0]                  penetration;

  modport source(output valid, normal, velocity_one, velocity_two, mass_one, mass_two,
                 has_second, restitution, penetration, input ready);
  modport sink(input valid, normal, velocity_one, velocity_two, mass_one, mass_two,
               has_second, restitution, penetration, output ready);
endinterface

interface pcr_out_if;
  logic                   valid;
  logic                   ready;
  logic [pcr_pkg::VW-1:0] new_velocity_one;
  logic [pcr_pkg::VW-1:0] new_velocity_two;
  logic [pcr_pkg::VW-1:0] shift_one;
  logic [pcr_pkg::VW-1:0] shift_two;

  modport source(output valid, new_velocity_one, new_velocity_two, shift_one, shift_two,
                 input ready);
  modport sink(input valid, new_velocity_one, new_velocity_two, shift_one, shift_two,
               output ready);
endinterface

// ===== rtl/pcr_div.sv =====
`timescale 1ns / 1ps
module pcr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pcr_pkg::QMAG-1:0]   mag,
  input  logic [pcr_pkg::MW-1:0]     num,
  input  logic [pcr_pkg::SW-1:0]     den,
  output logic [pcr_pkg::QMAG-1:0]   quo
);

  localparam int QM = pcr_pkg::QMAG;
  localparam int MW = pcr_pkg::MW;
  localparam int SW = pcr_pkg::SW;
  localparam int HALF = QM / 2;
  localparam int HW = QM - HALF;
  localparam int DVW = QM + SW;

  logic [HALF+MW-1:0] plo;
  logic [HW+MW-1:0]   phi;
  logic [SW-1:0]      den_a;
  logic [SW-1:0]      den_b;
  logic [DVW-1:0]     dvd;

  logic [SW-1:0] rem_r [QM];
  logic [QM-1:0] low_r [QM];
  logic [SW-1:0] dn_r  [QM];

  logic [SW-1:0] rem_i [QM];
  logic [QM-1:0] low_i [QM];
  logic [SW-1:0] dn_i  [QM];
  logic [SW:0]   trial [QM];
  logic [SW:0]   sub   [QM];
  logic          ge    [QM];

  // split product, then sum with half divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      plo   <= (HALF+MW)'(mag[HALF-1:0]) * (HALF+MW)'(num);
      phi   <= (HW+MW)'(mag[QM-1:HALF]) * (HW+MW)'(num);
      den_a <= den;
      dvd   <= (DVW'(phi) << HALF) + DVW'(plo) + DVW'(den_a >> 1);
      den_b <= den_a;
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int i = 0; i < QM; i++) begin
      if (i == 0) begin
        rem_i[i] = dvd[DVW-1:QM];
        low_i[i] = dvd[QM-1:0];
        dn_i[i]  = den_b;
      end else begin
        rem_i[i] = rem_r[i-1];
        low_i[i] = low_r[i-1];
        dn_i[i]  = dn_r[i-1];
      end
      trial[i] = {rem_i[i], low_i[i][QM-1]};
      sub[i]   = trial[i] - {1'b0, dn_i[i]};
      ge[i]    = (trial[i] >= {1'b0, dn_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QM; i++) begin
        rem_r[i] <= ge[i] ? sub[i][SW-1:0] : trial[i][SW-1:0];
        low_r[i] <= {low_i[i][QM-2:0], ge[i]};
        dn_r[i]  <= dn_i[i];
      end
    end
  end

  assign quo = low_r[QM-1];

endmodule

// ===== rtl/particle_collision_resolve.sv =====
`timescale 1ns / 1ps
// channel  | dir | contents
// contact  | in  | normal, velocities, masses, has_second, restitution, penetration
// result   | out | new velocities and position shifts
//
// one contact per cycle unless the result stalls; the mass divider sets the pipeline depth
// the divider takes one quotient bit per stage, eight of them run side by side
// reset clears only the stage valid bits
// a stalled result freezes the whole pipe; nothing is dropped or repeated
module particle_collision_resolve (
  input  logic       clk,
  input  logic       rst,
  pcr_in_if.sink     contact,
  pcr_out_if.source  result
);

  localparam int W    = pcr_pkg::W;
  localparam int AW   = 2 * W + 2;
  localparam int DFW  = 2 * W + 3;
  localparam int QW   = 2 * W + 14;
  localparam int SCW  = AW + 11;
  localparam int TW   = W + 16;
  localparam int QM   = pcr_pkg::QMAG;
  localparam int DW   = pcr_pkg::DW;
  localparam int PW   = 3 * W + 1;
  localparam int LAT  = pcr_pkg::DIV_LAT;
  localparam int NSTG = LAT + 7;
  localparam int MW   = pcr_pkg::MW;
  localparam int SW   = pcr_pkg::SW;
  localparam int KW   = pcr_pkg::KW;

  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv           = !vld[NSTG-1] || result.ready;
  assign contact.ready = adv && !rst;
  assign result.valid  = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], contact.valid};
    end
  end

  // input unpack
  logic signed [W-1:0] in_n  [3];
  logic signed [W-1:0] in_v1 [3];
  logic signed [W-1:0] in_v2 [3];
  logic [8:0]          in_r;
  logic [SW-1:0]       in_sum;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_n[c]  = contact.normal[c*W +: W];
      in_v1[c] = contact.velocity_one[c*W +: W];
      in_v2[c] = contact.velocity_two[c*W +: W];
    end
    in_r   = (contact.restitution > 9'(pcr_pkg::REST_ONE)) ? 9'(pcr_pkg::REST_ONE)
                                                           : contact.restitution;
    in_sum = SW'(contact.mass_one) + SW'(contact.mass_two);
  end

  // stage 1: products
  logic signed [W-1:0]   s1_n  [3];
  logic signed [W-1:0]   s1_v1 [3];
  logic signed [W-1:0]   s1_v2 [3];
  logic signed [2*W-1:0] s1_p1 [3];
  logic signed [2*W-1:0] s1_p2 [3];
  logic signed [TW-1:0]  s1_t  [3];
  logic [KW-1:0]         s1_k;
  logic                  s1_has;
  logic                  s1_pneg;
  logic [MW-1:0]         s1_m1;
  logic [MW-1:0]         s1_m2;
  logic [SW-1:0]         s1_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_n[c]  <= in_n[c];
        s1_v1[c] <= in_v1[c];
        s1_v2[c] <= in_v2[c];
        s1_p1[c] <= (2*W)'(in_n[c]) * (2*W)'(in_v1[c]);
        s1_p2[c] <= (2*W)'(in_n[c]) * (2*W)'(in_v2[c]);
        s1_t[c]  <= TW'(in_n[c]) * TW'(contact.penetration);
      end
      s1_k    <= KW'(pcr_pkg::REST_ONE) + KW'(in_r);
      s1_has  <= contact.has_second;
      s1_pneg <= contact.penetration < 0;
      if (in_sum == '0) begin
        s1_m1  <= MW'(1);
        s1_m2  <= MW'(1);
        s1_sum <= SW'(2);
      end else begin
        s1_m1  <= contact.mass_one;
        s1_m2  <= contact.mass_two;
        s1_sum <= in_sum;
      end
    end
  end

  // stage 2: projections
  logic signed [AW-1:0]  s2_a1;
  logic signed [DFW-1:0] s2_diff;
  logic signed [W-1:0]   s2_n  [3];
  logic signed [W-1:0]   s2_v1 [3];
  logic signed [W-1:0]   s2_v2 [3];
  logic signed [TW-1:0]  s2_t  [3];
  logic [KW-1:0]         s2_k;
  logic                  s2_has;
  logic                  s2_pneg;
  logic [MW-1:0]         s2_m1;
  logic [MW-1:0]         s2_m2;
  logic [SW-1:0]         s2_sum;
  logic signed [AW-1:0]  a1_c;
  logic signed [AW-1:0]  a2_c;

  always_comb begin
    a1_c = AW'(s1_p1[0]) + AW'(s1_p1[1]) + AW'(s1_p1[2]);
    a2_c = AW'(s1_p2[0]) + AW'(s1_p2[1]) + AW'(s1_p2[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a1   <= a1_c;
      s2_diff <= DFW'(a2_c) - DFW'(a1_c);
      for (int c = 0; c < 3; c++) begin
        s2_n[c]  <= s1_n[c];
        s2_v1[c] <= s1_v1[c];
        s2_v2[c] <= s1_v2[c];
        s2_t[c]  <= s1_t[c];
      end
      s2_k    <= s1_k;
      s2_has  <= s1_has;
      s2_pneg <= s1_pneg;
      s2_m1   <= s1_m1;
      s2_m2   <= s1_m2;
      s2_sum  <= s1_sum;
    end
  end

  // stage 3: restitution scale
  logic signed [QW-1:0]  s3_q;
  logic signed [SCW-1:0] s3_sc;
  logic signed [W-1:0]   s3_n  [3];
  logic signed [W-1:0]   s3_v1 [3];
  logic signed [W-1:0]   s3_v2 [3];
  logic signed [TW-1:0]  s3_t  [3];
  logic                  s3_has;
  logic                  s3_pneg;
  logic [MW-1:0]         s3_m1;
  logic [MW-1:0]         s3_m2;
  logic [SW-1:0]         s3_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_q  <= QW'(s2_diff) * QW'($signed({1'b0, s2_k}));
      s3_sc <= SCW'(s2_a1) * SCW'($signed({1'b0, s2_k}));
      for (int c = 0; c < 3; c++) begin
        s3_n[c]  <= s2_n[c];
        s3_v1[c] <= s2_v1[c];
        s3_v2[c] <= s2_v2[c];
        s3_t[c]  <= s2_t[c];
      end
      s3_has  <= s2_has;
      s3_pneg <= s2_pneg;
      s3_m1   <= s2_m1;
      s3_m2   <= s2_m2;
      s3_sum  <= s2_sum;
    end
  end

  // stage 4: magnitudes, scenery results
  pcr_pkg::side_t s4_side;
  logic [QM-1:0]  s4_qmag;
  logic [QM-1:0]  s4_tmag [3];
  logic [MW-1:0]  s4_m1;
  logic [MW-1:0]  s4_m2;
  logic [SW-1:0]  s4_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_qmag        <= QM'(pcr_pkg::abs64(64'(s3_q)));
      s4_side.qneg   <= s3_q < 0;
      s4_side.dscen  <= DW'(pcr_pkg::rnd_sm(s3_sc > 0, pcr_pkg::abs64(64'(s3_sc)),
                                            pcr_pkg::DSH));
      s4_side.has    <= s3_has;
      s4_side.pneg   <= s3_pneg;
      for (int c = 0; c < 3; c++) begin
        s4_tmag[c]             <= QM'(pcr_pkg::abs64(64'(s3_t[c])));
        s4_side.tneg[c]        <= s3_t[c] < 0;
        s4_side.sscen[c*W +: W] <= pcr_pkg::sat_comp(
          pcr_pkg::rnd_sm(s3_t[c] < 0, pcr_pkg::abs64(64'(s3_t[c])), pcr_pkg::SSH));
        s4_side.n[c*W +: W]    <= s3_n[c];
        s4_side.v1[c*W +: W]   <= s3_v1[c];
        s4_side.v2[c*W +: W]   <= s3_v2[c];
      end
      s4_m1  <= s3_m1;
      s4_m2  <= s3_m2;
      s4_sum <= s3_sum;
    end
  end

  // mass-weighted division
  logic [QM-1:0] w1;
  logic [QM-1:0] w2;
  logic [QM-1:0] ws1 [3];
  logic [QM-1:0] ws2 [3];

  pcr_div u_dq1 (.clk(clk), .en(adv), .mag(s4_qmag), .num(s4_m2), .den(s4_sum), .quo(w1));
  pcr_div u_dq2 (.clk(clk), .en(adv), .mag(s4_qmag), .num(s4_m1), .den(s4_sum), .quo(w2));

  for (genvar c = 0; c < 3; c++) begin : g_sdiv
    pcr_div u_ds1 (.clk(clk), .en(adv), .mag(s4_tmag[c]), .num(s4_m2), .den(s4_sum),
                   .quo(ws1[c]));
    pcr_div u_ds2 (.clk(clk), .en(adv), .mag(s4_tmag[c]), .num(s4_m1), .den(s4_sum),
                   .quo(ws2[c]));
  end

  pcr_pkg::side_t dl [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= s4_side;
      for (int i = 1; i < LAT; i++) begin
        dl[i] <= dl[i-1];
      end
    end
  end

  // post stage 1: normal deltas and shifts
  pcr_pkg::side_t       sd;
  logic signed [DW-1:0] d1_c;
  logic signed [DW-1:0] d2_c;
  pcr_pkg::vec_t        sh1_c;
  pcr_pkg::vec_t        sh2_c;

  always_comb begin
    sd = dl[LAT-1];
    if (sd.has) begin
      d1_c = DW'(pcr_pkg::rnd_sm(sd.qneg, 64'(w1), pcr_pkg::DSH));
      d2_c = DW'(pcr_pkg::rnd_sm(!sd.qneg, 64'(w2), pcr_pkg::DSH));
    end else begin
      d1_c = sd.dscen;
      d2_c = '0;
    end
    for (int c = 0; c < 3; c++) begin
      if (sd.pneg) begin
        sh1_c[c*W +: W] = '0;
        sh2_c[c*W +: W] = '0;
      end else if (sd.has) begin
        sh1_c[c*W +: W] = pcr_pkg::sat_comp(
          pcr_pkg::rnd_sm(sd.tneg[c], 64'(ws1[c]), pcr_pkg::SSH));
        sh2_c[c*W +: W] = pcr_pkg::sat_comp(
          pcr_pkg::rnd_sm(!sd.tneg[c], 64'(ws2[c]), pcr_pkg::SSH));
      end else begin
        sh1_c[c*W +: W] = sd.sscen[c*W +: W];
        sh2_c[c*W +: W] = '0;
      end
    end
  end

  logic signed [DW-1:0] p1_d1;
  logic signed [DW-1:0] p1_d2;
  pcr_pkg::vec_t        p1_s1;
  pcr_pkg::vec_t        p1_s2;
  pcr_pkg::vec_t        p1_n;
  pcr_pkg::vec_t        p1_v1;
  pcr_pkg::vec_t        p1_v2;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_d1 <= d1_c;
      p1_d2 <= d2_c;
      p1_s1 <= sh1_c;
      p1_s2 <= sh2_c;
      p1_n  <= sd.n;
      p1_v1 <= sd.v1;
      p1_v2 <= sd.v2;
    end
  end

  // post stage 2: project deltas back on the normal
  logic signed [PW-1:0] p2_pr1 [3];
  logic signed [PW-1:0] p2_pr2 [3];
  pcr_pkg::vec_t        p2_s1;
  pcr_pkg::vec_t        p2_s2;
  pcr_pkg::vec_t        p2_v1;
  pcr_pkg::vec_t        p2_v2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p2_pr1[c] <= PW'($signed(p1_n[c*W +: W])) * PW'(p1_d1);
        p2_pr2[c] <= PW'($signed(p1_n[c*W +: W])) * PW'(p1_d2);
      end
      p2_s1 <= p1_s1;
      p2_s2 <= p1_s2;
      p2_v1 <= p1_v1;
      p2_v2 <= p1_v2;
    end
  end

  // post stage 3: output register
  pcr_pkg::vec_t o_nv1;
  pcr_pkg::vec_t o_nv2;
  pcr_pkg::vec_t o_s1;
  pcr_pkg::vec_t o_s2;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        o_nv1[c*W +: W] <= pcr_pkg::sat_comp(64'($signed(p2_v1[c*W +: W])) +
          pcr_pkg::rnd_sm(p2_pr1[c] < 0, pcr_pkg::abs64(64'(p2_pr1[c])), pcr_pkg::VSH));
        o_nv2[c*W +: W] <= pcr_pkg::sat_comp(64'($signed(p2_v2[c*W +: W])) +
          pcr_pkg::rnd_sm(p2_pr2[c] < 0, pcr_pkg::abs64(64'(p2_pr2[c])), pcr_pkg::VSH));
      end
      o_s1 <= p2_s1;
      o_s2 <= p2_s2;
    end
  end

  assign result.new_velocity_one = o_nv1;
  assign result.new_velocity_two = o_nv2;
  assign result.shift_one        = o_s1;
  assign result.shift_two        = o_s2;

endmodule
